// File: sv/framebuffer_plot_dirty_rect_unit_assert.svh
// Assertion macros for the frame store unit.
`ifndef FRAMEBUFFER_PLOT_DIRTY_RECT_UNIT_ASSERT_SVH
`define FRAMEBUFFER_PLOT_DIRTY_RECT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FPDR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define FPDR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FPDR_ASSERT(lbl, prop, msg)
`define FPDR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: sv/fpdr_pkg.sv
`default_nettype none

package fpdr_pkg;

    localparam int WORD_BITS         = 16;
    localparam int MAX_WIDTH         = 256;
    localparam int MAX_HEIGHT        = 128;
    localparam int WORDS_PER_ROW_MAX = MAX_WIDTH / WORD_BITS;
    localparam int STORE_DEPTH       = WORDS_PER_ROW_MAX * MAX_HEIGHT;
    localparam int ADDR_BITS         = $clog2(STORE_DEPTH);

    localparam logic [1:0] CFG_WIDTH_PIXELS = 2'd0;
    localparam logic [1:0] CFG_HEIGHT_ROWS  = 2'd1;
    localparam logic [1:0] CFG_AUTO_UPDATE  = 2'd2;

    localparam logic KIND_PLOT  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY
    } t_state;

endpackage

`default_nettype wire

// File: sv/framebuffer_plot_dirty_rect_unit.sv
`default_nettype none
// Monochrome frame store of 2048 words of 16 pixels each, with single pixel plot and
// dirty rectangle tracking. After reset the store is swept to zero, one word per cycle,
// and input stays stalled during that sweep while configuration
// writes are taken as usual. For each item the addressed word is read from the frame store
// on acceptance, then modified, written back and registered once the output is free.
// The result register lets the next item be taken while a finished result waits.
// A plot outside the configured size is flagged and changes nothing. A flush of an open
// batch, or an in-range plot with auto update on, reports the dirty rectangle and closes
// the batch. The user must write configuration only while no item is in flight; unchecked.

`include "framebuffer_plot_dirty_rect_unit_assert.svh"

module framebuffer_plot_dirty_rect_unit
    import fpdr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_pos_x,
    input  wire logic [6:0]  i_pos_y,
    input  wire logic        i_colour,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_dirty,
    output logic [7:0]       o_min_x,
    output logic [7:0]       o_max_x,
    output logic [6:0]       o_min_y,
    output logic [6:0]       o_max_y,
    output logic [15:0]      o_word_value,
    output logic             o_out_of_range
);

    logic [8:0] r_width_pixels;
    logic [7:0] r_height_rows;
    logic       r_auto_update;

    t_state r_state, n_state;

    logic [WORD_BITS-1:0] r_mem [STORE_DEPTH];
    logic [WORD_BITS-1:0] r_rd_data;
    logic [ADDR_BITS-1:0] r_clr_addr;

    logic                 r_kind;
    logic [7:0]           r_x;
    logic [6:0]           r_y;
    logic                 r_colour;
    logic                 r_oor;
    logic [ADDR_BITS-1:0] r_addr;

    logic       r_batch_open, n_batch_open;
    logic [8:0] r_low_x, n_low_x;
    logic [7:0] r_high_x, n_high_x;
    logic [7:0] r_low_y, n_low_y;
    logic [6:0] r_high_y, n_high_y;

    logic        r_out_valid;
    logic        r_dirty, n_dirty;
    logic [7:0]  r_min_x, n_min_x;
    logic [7:0]  r_max_x, n_max_x;
    logic [6:0]  r_min_y, n_min_y;
    logic [6:0]  r_max_y, n_max_y;
    logic [15:0] r_word, n_word;
    logic        r_oor_out, n_oor_out;

    logic [8:0]           eff_width;
    logic [7:0]           eff_height;
    logic [4:0]           words_per_row;
    logic [11:0]          addr_full;
    logic                 in_oor;
    logic                 in_accept;
    logic                 out_free;
    logic                 rd_en;
    logic                 wr_en;
    logic                 load_out;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] new_word;
    logic [7:0]           col_lo;
    logic [7:0]           col_hi;
    logic [8:0]           base_low_x;
    logic [7:0]           base_high_x;
    logic [7:0]           base_low_y;
    logic [6:0]           base_high_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_pixels <= 9'd128;
            r_height_rows  <= 8'd64;
            r_auto_update  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WIDTH_PIXELS: r_width_pixels <= i_cfg_data;
                CFG_HEIGHT_ROWS:  r_height_rows  <= i_cfg_data[7:0];
                CFG_AUTO_UPDATE:  r_auto_update  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width_pixels > 9'(MAX_WIDTH)) begin
            eff_width = 9'(MAX_WIDTH);
        end else begin
            eff_width = {r_width_pixels[8:4], 4'b0000};
        end
        if (r_height_rows > 8'(MAX_HEIGHT)) begin
            eff_height = 8'(MAX_HEIGHT);
        end else begin
            eff_height = r_height_rows;
        end
    end

    assign words_per_row = eff_width[8:4];
    assign addr_full     = 12'(i_pos_y) * 12'(words_per_row) + 12'(i_pos_x[7:4]);
    assign in_oor        = ({1'b0, i_pos_x} >= eff_width) || ({1'b0, i_pos_y} >= eff_height);
    assign in_accept     = i_in_valid && !o_in_stall;
    assign out_free      = !r_out_valid || !i_out_stall;

    assign mask     = 16'h8000 >> r_x[3:0];
    assign new_word = r_colour ? (r_rd_data | mask) : (r_rd_data & ~mask);
    assign col_lo   = {r_x[7:4], 4'b0000};
    assign col_hi   = {r_x[7:4], 4'b1000};

    always_comb begin
        if (r_batch_open) begin
            base_low_x  = r_low_x;
            base_high_x = r_high_x;
            base_low_y  = r_low_y;
            base_high_y = r_high_y;
        end else begin
            base_low_x  = eff_width;
            base_high_x = 8'd0;
            base_low_y  = eff_height;
            base_high_y = 7'd0;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_stall   = 1'b1;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_addr;
        wr_data      = new_word;
        load_out     = 1'b0;
        n_batch_open = r_batch_open;
        n_low_x      = r_low_x;
        n_high_x     = r_high_x;
        n_low_y      = r_low_y;
        n_high_y     = r_high_y;
        n_dirty      = 1'b0;
        n_min_x      = 8'd0;
        n_max_x      = 8'd0;
        n_min_y      = 7'd0;
        n_max_y      = 7'd0;
        n_word       = 16'd0;
        n_oor_out    = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = '0;
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                rd_en      = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_MODIFY;
                end
            end
            ST_MODIFY: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                    if (r_kind == KIND_FLUSH) begin
                        if (r_batch_open) begin
                            n_batch_open = 1'b0;
                            n_dirty      = 1'b1;
                            n_min_x      = r_low_x[7:0];
                            n_max_x      = r_high_x;
                            n_min_y      = r_low_y[6:0];
                            n_max_y      = r_high_y;
                        end
                    end else if (r_oor) begin
                        n_oor_out = 1'b1;
                    end else begin
                        wr_en        = 1'b1;
                        n_word       = new_word;
                        n_batch_open = 1'b1;
                        n_low_x  = ({1'b0, col_lo} < base_low_x) ? {1'b0, col_lo} : base_low_x;
                        n_high_x = (col_hi > base_high_x) ? col_hi : base_high_x;
                        n_low_y  = ({1'b0, r_y} < base_low_y) ? {1'b0, r_y} : base_low_y;
                        n_high_y = (r_y > base_high_y) ? r_y : base_high_y;
                        if (r_auto_update) begin
                            n_batch_open = 1'b0;
                            n_dirty      = 1'b1;
                            n_min_x      = n_low_x[7:0];
                            n_max_x      = n_high_x;
                            n_min_y      = n_low_y[6:0];
                            n_max_y      = n_high_y;
                        end
                    end
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_batch_open <= 1'b0;
            r_low_x      <= '0;
            r_high_x     <= '0;
            r_low_y      <= '0;
            r_high_y     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_batch_open <= n_batch_open;
            r_low_x      <= n_low_x;
            r_high_x     <= n_high_x;
            r_low_y      <= n_low_y;
            r_high_y     <= n_high_y;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind   <= i_kind;
            r_x      <= i_pos_x;
            r_y      <= i_pos_y;
            r_colour <= i_colour;
            r_oor    <= in_oor;
            r_addr   <= addr_full[ADDR_BITS-1:0];
        end
        if (load_out) begin
            r_dirty   <= n_dirty;
            r_min_x   <= n_min_x;
            r_max_x   <= n_max_x;
            r_min_y   <= n_min_y;
            r_max_y   <= n_max_y;
            r_word    <= n_word;
            r_oor_out <= n_oor_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[addr_full[ADDR_BITS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_dirty        = r_dirty;
    assign o_min_x        = r_min_x;
    assign o_max_x        = r_max_x;
    assign o_min_y        = r_min_y;
    assign o_max_y        = r_max_y;
    assign o_word_value   = r_word;
    assign o_out_of_range = r_oor_out;

    `FPDR_ASSERT(a_write_owner, wr_en |-> (r_state == ST_CLEAR || r_state == ST_MODIFY), "frame store written outside clear or modify")
    `FPDR_ASSERT(a_accept_to_modify, in_accept |=> (r_state == ST_MODIFY && o_in_stall), "accepted item did not enter modify")
    `FPDR_ASSERT(a_result_source, $rose(r_out_valid) |-> $past(r_state == ST_MODIFY), "result appeared without a modify cycle")
    `FPDR_ASSERT(a_flag_exclusive, r_out_valid |-> !(r_oor_out && (r_dirty || r_word != 16'd0)), "out of range result carries data")
    `FPDR_ASSERT_ALWAYS(a_reset_idle_out, !i_rst_n |=> !r_out_valid, "result valid right after reset")

endmodule

`default_nettype wire
